/* sv/bresenham_line_rasterizer_defines.svh */
// ----------------------------------------------------------------------------
// bresenham line rasterizer assertion macros
// shorthand for the concurrent checks in the top level
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// condition must never hold
`define BLR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/blr_pkg.sv */
// ----------------------------------------------------------------------------
// blr_pkg
// shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
package blr_pkg;

	localparam int COORD_BITS = 6;
	// decision variable spans -2*major .. 2*minor, plus sign and margin
	localparam int ERR_BITS   = COORD_BITS + 3;
	// setup queue depth, power of two
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [ERR_BITS-1:0] err_t;
	typedef logic [Q_PTR_BITS-1:0]      q_ptr_t;
	typedef logic [Q_CNT_BITS-1:0]      q_cnt_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   last_pixel;
	} pix_t;

	// classified segment, ready to walk
	typedef struct packed {
		coord_t ma0;
		coord_t mi0;
		coord_t major;
		coord_t minor;
		logic   steep;
		logic   down;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* sv/blr_front.sv */
// ----------------------------------------------------------------------------
// blr_front
// accepts segments, measures spans and orders endpoints along the major axis
// ----------------------------------------------------------------------------
module blr_front import blr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    seg_valid,
	output logic    seg_stall,
	input  seg_t    seg,
	output logic    push,
	output job_t    push_job,
	input  q_stat_t q_stat
);

	logic   valid_s1;
	seg_t   seg_s1;
	coord_t dx_s1;
	coord_t dy_s1;
	logic   steep_s1;

	logic   accept;
	coord_t dx;
	coord_t dy;
	coord_t ma0, mi0, ma1, mi1;
	coord_t major, minor;
	logic   swap;

	assign seg_stall = valid_s1 & q_stat.full;
	assign accept    = seg_valid & ~seg_stall;
	assign push      = valid_s1 & ~q_stat.full;

	assign dx = (seg.end_x > seg.start_x) ? seg.end_x - seg.start_x : seg.start_x - seg.end_x;
	assign dy = (seg.end_y > seg.start_y) ? seg.end_y - seg.start_y : seg.start_y - seg.end_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_s1   <= seg;
			dx_s1    <= dx;
			dy_s1    <= dy;
			steep_s1 <= (dy > dx);
		end
	end

	always_comb begin
		if (steep_s1) begin
			ma0   = seg_s1.start_y;
			mi0   = seg_s1.start_x;
			ma1   = seg_s1.end_y;
			mi1   = seg_s1.end_x;
			major = dy_s1;
			minor = dx_s1;
		end else begin
			ma0   = seg_s1.start_x;
			mi0   = seg_s1.start_y;
			ma1   = seg_s1.end_x;
			mi1   = seg_s1.end_y;
			major = dx_s1;
			minor = dy_s1;
		end
		// walk always runs toward increasing major coordinate
		swap           = ma1 < ma0;
		push_job.ma0   = swap ? ma1 : ma0;
		push_job.mi0   = swap ? mi1 : mi0;
		push_job.major = major;
		push_job.minor = minor;
		push_job.steep = steep_s1;
		push_job.down  = swap ? (mi0 < mi1) : (mi1 < mi0);
	end

endmodule

/* sv/blr_queue.sv */
// ----------------------------------------------------------------------------
// blr_queue
// small fifo of classified segments between front and walker
// ----------------------------------------------------------------------------
module blr_queue import blr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head_job,
	output q_stat_t q_stat
);

	job_t   entries_q [Q_DEPTH];
	q_ptr_t wr_q;
	q_ptr_t rd_q;
	q_cnt_t cnt_q;

	assign q_stat.full  = (cnt_q == q_cnt_t'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head_job     = entries_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_job;
		end
	end

endmodule

/* sv/blr_walk.sv */
// ----------------------------------------------------------------------------
// blr_walk
// steps one pixel per unstalled cycle along the major axis into an output reg
// ----------------------------------------------------------------------------
module blr_walk import blr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  job_t    head_job,
	output logic    pop,
	output logic    pix_valid,
	input  logic    pix_stall,
	output pix_t    pix
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	coord_t mj_q;
	coord_t mn_q;
	coord_t left_q;
	err_t   err_q;
	err_t   inc_a_q;
	err_t   inc_b_q;
	logic   steep_q;
	logic   down_q;
	logic   pix_valid_q;
	pix_t   pix_q;

	logic   out_adv;
	logic   emit;
	logic   last;
	err_t   minor2;
	err_t   major2;

	assign out_adv = ~pix_valid_q | ~pix_stall;
	assign emit    = (state_q == ST_RUN) & out_adv;
	assign last    = (left_q == '0);
	assign pop     = ~q_stat.empty & ((state_q == ST_IDLE) | (emit & last));

	assign minor2 = err_t'({head_job.minor, 1'b0});
	assign major2 = err_t'({head_job.major, 1'b0});

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mj_q        <= '0;
			mn_q        <= '0;
			left_q      <= '0;
			err_q       <= '0;
			inc_a_q     <= '0;
			inc_b_q     <= '0;
			steep_q     <= 1'b0;
			down_q      <= 1'b0;
			pix_valid_q <= 1'b0;
			pix_q       <= '0;
		end else begin
			if (emit) begin
				pix_valid_q      <= 1'b1;
				pix_q.pixel_x    <= steep_q ? mn_q : mj_q;
				pix_q.pixel_y    <= steep_q ? mj_q : mn_q;
				pix_q.last_pixel <= last;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end

			if (pop) begin
				state_q <= ST_RUN;
				mj_q    <= head_job.ma0;
				mn_q    <= head_job.mi0;
				left_q  <= head_job.major;
				err_q   <= minor2 - err_t'(head_job.major);
				inc_a_q <= minor2 - major2;
				inc_b_q <= minor2;
				steep_q <= head_job.steep;
				down_q  <= head_job.down;
			end else if (emit) begin
				if (last) begin
					state_q <= ST_IDLE;
				end else begin
					mj_q   <= mj_q + 1'b1;
					left_q <= left_q - 1'b1;
					// non-negative decision variable steps the minor axis
					if (!err_q[ERR_BITS-1]) begin
						mn_q  <= down_q ? mn_q - 1'b1 : mn_q + 1'b1;
						err_q <= err_q + inc_a_q;
					end else begin
						err_q <= err_q + inc_b_q;
					end
				end
			end
		end
	end

endmodule

/* sv/bresenham_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// emits every pixel of a segment by integer stepping in all octants
// ----------------------------------------------------------------------------
//  channel | signals                     | payload
//  --------+-----------------------------+------------------------------------
//  segment | seg_valid, seg_stall        | seg: start_x start_y end_x end_y
//  pixel   | pix_valid, pix_stall        | pix: pixel_x pixel_y last_pixel
//
//  a segment gives major + 1 pixel items (1 to 64), one per unstalled cycle
//  from the walk stepper; its first pixel passes the front, queue and walker
//  registers to the output register; a two-entry setup queue lets segments
//  enter while the walker is busy; a stall on a held pixel freezes the walker
//  segments stall when the queue is full and the front stage holds one
//  reset clears all valid flags and the walker goes idle
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_defines.svh"

module bresenham_line_rasterizer import blr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic seg_valid,
	output logic seg_stall,
	input  seg_t seg,
	output logic pix_valid,
	input  logic pix_stall,
	output pix_t pix
);

	logic    push;
	job_t    push_job;
	logic    pop;
	job_t    head_job;
	q_stat_t q_stat;

	blr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.push      (push),
		.push_job  (push_job),
		.q_stat    (q_stat)
	);

	blr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	blr_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_job  (head_job),
		.pop       (pop),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

	`BLR_ASSERT_NEVER(a_push_full, clk, arst_n, push && q_stat.full, "push into full queue")
	`BLR_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && q_stat.empty, "pop from empty queue")
	`BLR_ASSERT_NEXT(a_push_fill, clk, arst_n, push && q_stat.empty, !q_stat.empty, "queue lost item")
	`BLR_ASSERT_NEXT(a_walk_gap, clk, arst_n, pix_valid && !pix_stall && !pix.last_pixel, pix_valid, "gap inside segment")

endmodule
